// ===== hdl/rlps_pkg.sv =====
package rlps_pkg;

  // pixel geometry
  localparam int unsigned BITS_PER_COLOR = 8;
  localparam int unsigned PIXEL_BITS     = 3 * BITS_PER_COLOR;
  localparam int unsigned BCNT_W         = $clog2(PIXEL_BITS + 1);
  localparam int unsigned LEN_W          = 16;

  // configuration register file
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = LEN_W;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 3'd4;

  localparam logic [LEN_W-1:0] ZERO_HIGH_RST = 16'd18;
  localparam logic [LEN_W-1:0] ZERO_LOW_RST  = 16'd40;
  localparam logic [LEN_W-1:0] ONE_HIGH_RST  = 16'd40;
  localparam logic [LEN_W-1:0] ONE_LOW_RST   = 16'd30;
  localparam logic [LEN_W-1:0] LATCH_RST     = 16'd2500;

  // item opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0] zero_high_cycles;
    logic [LEN_W-1:0] zero_low_cycles;
    logic [LEN_W-1:0] one_high_cycles;
    logic [LEN_W-1:0] one_low_cycles;
    logic [LEN_W-1:0] latch_cycles;
  } cfg_t;

  typedef struct packed {
    logic                      opcode;
    logic [BITS_PER_COLOR-1:0] red;
    logic [BITS_PER_COLOR-1:0] green;
    logic [BITS_PER_COLOR-1:0] blue;
    logic                      last_pixel;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic pixel_accepted;
  } result_t;

  // phase length to counter load; a zero length counts as one tick
  function automatic logic [LEN_W-1:0] len_m1(input logic [LEN_W-1:0] len);
    len_m1 = (len == '0) ? '0 : len - 1'b1;
  endfunction

endpackage

// ===== hdl/rlps_cfg_regs.sv =====
module rlps_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rlps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rlps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output rlps_pkg::cfg_t                     cfg
);

  rlps_pkg::cfg_t cfg_r;

  // timing registers; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_high_cycles <= rlps_pkg::ZERO_HIGH_RST;
      cfg_r.zero_low_cycles  <= rlps_pkg::ZERO_LOW_RST;
      cfg_r.one_high_cycles  <= rlps_pkg::ONE_HIGH_RST;
      cfg_r.one_low_cycles   <= rlps_pkg::ONE_LOW_RST;
      cfg_r.latch_cycles     <= rlps_pkg::LATCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rlps_pkg::REG_ZERO_HIGH: cfg_r.zero_high_cycles <= cfg_wdata;
        rlps_pkg::REG_ZERO_LOW:  cfg_r.zero_low_cycles  <= cfg_wdata;
        rlps_pkg::REG_ONE_HIGH:  cfg_r.one_high_cycles  <= cfg_wdata;
        rlps_pkg::REG_ONE_LOW:   cfg_r.one_low_cycles   <= cfg_wdata;
        rlps_pkg::REG_LATCH:     cfg_r.latch_cycles     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/rlps_engine.sv =====
module rlps_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  rlps_pkg::item_t   item,
  input  rlps_pkg::cfg_t    cfg,
  output rlps_pkg::result_t res
);

  localparam int unsigned PB = rlps_pkg::PIXEL_BITS;
  localparam int unsigned BW = rlps_pkg::BCNT_W;
  localparam int unsigned LW = rlps_pkg::LEN_W;

  rlps_pkg::phase_t phase_r, phase_nxt;
  logic [LW-1:0]    cnt_r, cnt_nxt;
  logic [PB-1:0]    shift_r, shift_nxt;
  logic [BW-1:0]    bits_r, bits_nxt;
  logic             shift_last_r, shift_last_nxt;
  logic [PB-1:0]    pend_pix_r, pend_pix_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic             pend_last_r, pend_last_nxt;
  logic             accepted;

  // bit lengths picked by the bit being sent
  function automatic logic [LW-1:0] high_len(input logic b, input rlps_pkg::cfg_t c);
    high_len = rlps_pkg::len_m1(b ? c.one_high_cycles : c.zero_high_cycles);
  endfunction

  function automatic logic [LW-1:0] low_len(input logic b, input rlps_pkg::cfg_t c);
    low_len = rlps_pkg::len_m1(b ? c.one_low_cycles : c.zero_low_cycles);
  endfunction

  // next state for one beat
  always_comb begin
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    shift_nxt      = shift_r;
    bits_nxt       = bits_r;
    shift_last_nxt = shift_last_r;
    pend_pix_nxt   = pend_pix_r;
    pend_vld_nxt   = pend_vld_r;
    pend_last_nxt  = pend_last_r;
    accepted       = 1'b0;

    if (item.opcode == rlps_pkg::OP_PUSH) begin
      // one-entry buffer, GRB order
      if (!pend_vld_r) begin
        pend_pix_nxt  = {item.green, item.red, item.blue};
        pend_last_nxt = item.last_pixel;
        pend_vld_nxt  = 1'b1;
        accepted      = 1'b1;
      end
    end else begin
      case (phase_r)
        rlps_pkg::PH_IDLE: begin
          if (pend_vld_r) begin
            shift_nxt      = pend_pix_r;
            shift_last_nxt = pend_last_r;
            bits_nxt       = BW'(PB);
            pend_vld_nxt   = 1'b0;
            phase_nxt      = rlps_pkg::PH_HIGH;
            cnt_nxt        = high_len(pend_pix_r[PB-1], cfg);
          end
        end
        rlps_pkg::PH_HIGH: begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
          end else begin
            phase_nxt = rlps_pkg::PH_LOW;
            cnt_nxt   = low_len(shift_r[PB-1], cfg);
          end
        end
        rlps_pkg::PH_LOW: begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
          end else begin
            if (bits_r != '0) begin
              shift_nxt = {shift_r[PB-2:0], 1'b0};
              bits_nxt  = bits_r - 1'b1;
            end
            if (bits_nxt != '0) begin
              phase_nxt = rlps_pkg::PH_HIGH;
              cnt_nxt   = high_len(shift_nxt[PB-1], cfg);
            end else if (shift_last_r) begin
              phase_nxt = rlps_pkg::PH_LATCH;
              cnt_nxt   = rlps_pkg::len_m1(cfg.latch_cycles);
            end else if (pend_vld_r) begin
              shift_nxt      = pend_pix_r;
              shift_last_nxt = pend_last_r;
              bits_nxt       = BW'(PB);
              pend_vld_nxt   = 1'b0;
              phase_nxt      = rlps_pkg::PH_HIGH;
              cnt_nxt        = high_len(pend_pix_r[PB-1], cfg);
            end
            // else hold low mid-frame until a pixel arrives
          end
        end
        rlps_pkg::PH_LATCH: begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
          end else if (pend_vld_r) begin
            shift_nxt      = pend_pix_r;
            shift_last_nxt = pend_last_r;
            bits_nxt       = BW'(PB);
            pend_vld_nxt   = 1'b0;
            phase_nxt      = rlps_pkg::PH_HIGH;
            cnt_nxt        = high_len(pend_pix_r[PB-1], cfg);
          end else begin
            phase_nxt = rlps_pkg::PH_IDLE;
          end
        end
        default: phase_nxt = rlps_pkg::PH_IDLE;
      endcase
    end

    res.line_level     = (phase_nxt == rlps_pkg::PH_HIGH);
    res.busy_res       = (phase_nxt != rlps_pkg::PH_IDLE);
    res.pixel_accepted = accepted;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= rlps_pkg::PH_IDLE;
      cnt_r        <= '0;
      shift_r      <= '0;
      bits_r       <= '0;
      shift_last_r <= 1'b0;
      pend_vld_r   <= 1'b0;
      pend_last_r  <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      cnt_r        <= cnt_nxt;
      shift_r      <= shift_nxt;
      bits_r       <= bits_nxt;
      shift_last_r <= shift_last_nxt;
      pend_vld_r   <= pend_vld_nxt;
      pend_last_r  <= pend_last_nxt;
    end
  end

  // buffered pixel, only read while valid
  always_ff @(posedge clk) begin
    if (fire) begin
      pend_pix_r <= pend_pix_nxt;
    end
  end

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= BW'(PB))
    else $error("bit count out of range");

  a_high_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rlps_pkg::PH_HIGH |-> bits_r != '0)
    else $error("high pulse with no bits left");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == rlps_pkg::OP_PUSH && !pend_vld_r |=> pend_vld_r)
    else $error("accepted pixel not buffered");

  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.opcode == rlps_pkg::OP_TICK && phase_r == rlps_pkg::PH_IDLE && !pend_vld_r
    |=> phase_r == rlps_pkg::PH_IDLE)
    else $error("left idle with empty buffer");

endmodule

// ===== hdl/rgb_led_pulse_serializer.sv =====
// channel   direction  handshake          payload
// in_*      input      in_valid/in_stall   opcode, red, green, blue, last_pixel
// out_*     output     out_valid/out_stall line_level, busy_res, pixel_accepted
// cfg_*     input      cfg_we              cfg_index, cfg_wdata
//
// One beat per cycle sustained while out_stall does not hold the result register; a taken beat
// passes the input register, then the state update into the result register, before the out_ ports.
// The serializer state advances once per beat, in the cycle it leaves the input register.
// rst_n is synchronous: timing registers return to defaults, line idles low.
// out_stall holds the result register and back-pressures in_stall in the same cycle.
module rgb_led_pulse_serializer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_opcode,
  input  logic [rlps_pkg::BITS_PER_COLOR-1:0]  in_red,
  input  logic [rlps_pkg::BITS_PER_COLOR-1:0]  in_green,
  input  logic [rlps_pkg::BITS_PER_COLOR-1:0]  in_blue,
  input  logic                                 in_last_pixel,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_line_level,
  output logic                                 out_busy_res,
  output logic                                 out_pixel_accepted,
  input  logic                                 cfg_we,
  input  logic [rlps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rlps_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  rlps_pkg::cfg_t    cfg;
  rlps_pkg::item_t   item_r;
  rlps_pkg::result_t res;
  rlps_pkg::result_t res_r;
  logic              in_vld_r;
  logic              out_vld_r;
  logic              advance;
  logic              fire;
  logic              in_take;

  // result register free or draining this cycle
  assign advance  = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  rlps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.opcode     <= in_opcode;
      item_r.red        <= in_red;
      item_r.green      <= in_green;
      item_r.blue       <= in_blue;
      item_r.last_pixel <= in_last_pixel;
    end
  end

  rlps_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_line_level     = res_r.line_level;
  assign out_busy_res       = res_r.busy_res;
  assign out_pixel_accepted = res_r.pixel_accepted;

endmodule

// ===== test/rlps_pulse_check.sv =====
module rlps_pulse_check (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 in_opcode,
  input  logic [rlps_pkg::BITS_PER_COLOR-1:0]  in_red,
  input  logic [rlps_pkg::BITS_PER_COLOR-1:0]  in_green,
  input  logic [rlps_pkg::BITS_PER_COLOR-1:0]  in_blue,
  input  logic                                 in_last_pixel,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic                                 out_line_level,
  input  logic                                 out_busy_res,
  input  logic                                 out_pixel_accepted,
  input  logic                                 cfg_we,
  input  logic [rlps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rlps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output int                                   fail_count,
  output int                                   pending_results,
  output int                                   results_checked,
  output int                                   pixels_taken
);

  localparam int unsigned PB = rlps_pkg::PIXEL_BITS;
  localparam int unsigned BW = rlps_pkg::BCNT_W;
  localparam int unsigned LW = rlps_pkg::LEN_W;

  localparam logic [BW-1:0] FULL_PIXEL = BW'(PB);

  // shadow of the serializer state and its timing registers
  rlps_pkg::cfg_t   timing;
  rlps_pkg::phase_t phase;
  logic [PB-1:0]    shifter;
  logic [BW-1:0]    bits_left;
  logic [LW-1:0]    count;
  logic             shifter_last;
  logic [PB-1:0]    held_pixel;
  logic             held_valid;
  logic             held_last;

  // predicted line states, oldest first
  rlps_pkg::result_t line_states_q[$];

  // counter preload: a phase of length L runs L ticks, zero acts as one
  function automatic logic [LW-1:0] count_load(input logic [LW-1:0] len);
    count_load = (len == '0) ? len : len - 1'b1;
  endfunction

  task automatic begin_high();
    phase = rlps_pkg::PH_HIGH;
    count = count_load(shifter[PB-1] ? timing.one_high_cycles
                                     : timing.zero_high_cycles);
  endtask

  // move the buffered pixel into the shifter; this tick is its first high tick
  task automatic load_shifter();
    shifter      = held_pixel;
    shifter_last = held_last;
    bits_left    = FULL_PIXEL;
    held_valid   = 1'b0;
    begin_high();
  endtask

  // one clock of the output waveform
  task automatic line_tick();
    case (phase)
      rlps_pkg::PH_IDLE: begin
        if (held_valid) load_shifter();
      end
      rlps_pkg::PH_HIGH: begin
        if (count != '0) begin
          count = count - 1'b1;
        end else begin
          phase = rlps_pkg::PH_LOW;
          count = count_load(shifter[PB-1] ? timing.one_low_cycles
                                           : timing.zero_low_cycles);
        end
      end
      rlps_pkg::PH_LOW: begin
        if (count != '0) begin
          count = count - 1'b1;
        end else begin
          if (bits_left != '0) begin
            shifter   = {shifter[PB-2:0], 1'b0};
            bits_left = bits_left - 1'b1;
          end
          if (bits_left != '0) begin
            begin_high();
          end else if (shifter_last) begin
            phase = rlps_pkg::PH_LATCH;
            count = count_load(timing.latch_cycles);
          end else if (held_valid) begin
            load_shifter();
          end
          // else: buffer ran dry mid-frame, line sits low and stays busy
        end
      end
      default: begin
        if (count != '0) begin
          count = count - 1'b1;
        end else begin
          phase = rlps_pkg::PH_IDLE;
          if (held_valid) load_shifter();
        end
      end
    endcase
  endtask

  // apply one input beat and work out the line state it leaves
  task automatic predict_line_state(input rlps_pkg::item_t beat,
                                    output rlps_pkg::result_t state);
    logic taken;
    taken = 1'b0;
    if (beat.opcode == rlps_pkg::OP_PUSH) begin
      if (!held_valid) begin
        held_pixel = {beat.green, beat.red, beat.blue};
        held_last  = beat.last_pixel;
        held_valid = 1'b1;
        taken      = 1'b1;
      end
    end else begin
      line_tick();
    end
    state.line_level     = (phase == rlps_pkg::PH_HIGH);
    state.busy_res       = (phase != rlps_pkg::PH_IDLE);
    state.pixel_accepted = taken;
  endtask

  always @(posedge clk) begin : watch
    rlps_pkg::item_t   beat;
    rlps_pkg::result_t want;
    rlps_pkg::result_t got;
    if (!rst_n) begin
      timing.zero_high_cycles = rlps_pkg::ZERO_HIGH_RST;
      timing.zero_low_cycles  = rlps_pkg::ZERO_LOW_RST;
      timing.one_high_cycles  = rlps_pkg::ONE_HIGH_RST;
      timing.one_low_cycles   = rlps_pkg::ONE_LOW_RST;
      timing.latch_cycles     = rlps_pkg::LATCH_RST;
      phase        = rlps_pkg::PH_IDLE;
      shifter      = '0;
      bits_left    = '0;
      count        = '0;
      shifter_last = 1'b0;
      held_pixel   = '0;
      held_valid   = 1'b0;
      held_last    = 1'b0;
      line_states_q.delete();
      fail_count      = 0;
      results_checked = 0;
      pixels_taken    = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          rlps_pkg::REG_ZERO_HIGH: timing.zero_high_cycles = cfg_wdata;
          rlps_pkg::REG_ZERO_LOW:  timing.zero_low_cycles  = cfg_wdata;
          rlps_pkg::REG_ONE_HIGH:  timing.one_high_cycles  = cfg_wdata;
          rlps_pkg::REG_ONE_LOW:   timing.one_low_cycles   = cfg_wdata;
          rlps_pkg::REG_LATCH:     timing.latch_cycles     = cfg_wdata;
          default: ;
        endcase
      end

      // input beat
      if (in_valid && !in_stall) begin
        beat.opcode     = in_opcode;
        beat.red        = in_red;
        beat.green      = in_green;
        beat.blue       = in_blue;
        beat.last_pixel = in_last_pixel;
        predict_line_state(beat, want);
        line_states_q.push_back(want);
      end

      // result beat
      if (out_valid && !out_stall) begin
        got.line_level     = out_line_level;
        got.busy_res       = out_busy_res;
        got.pixel_accepted = out_pixel_accepted;
        if (line_states_q.size() == 0) begin
          if (fail_count < 10)
            $display("result with nothing pending: line=%0b busy=%0b taken=%0b",
                     got.line_level, got.busy_res, got.pixel_accepted);
          fail_count++;
        end else begin
          want = line_states_q.pop_front();
          if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
              got.pixel_accepted !== want.pixel_accepted) begin
            if (fail_count < 10)
              $display("result %0d: expected line=%0b busy=%0b taken=%0b, ",
                       results_checked, want.line_level, want.busy_res,
                       want.pixel_accepted,
                       "got line=%0b busy=%0b taken=%0b",
                       got.line_level, got.busy_res, got.pixel_accepted);
            fail_count++;
          end
          results_checked++;
          if (got.pixel_accepted === 1'b1) pixels_taken++;
        end
      end
    end
    pending_results = line_states_q.size();
  end

endmodule

// ===== test/tb_rgb_led_pulse_serializer.sv =====
module tb_rgb_led_pulse_serializer;

  localparam int unsigned CB = rlps_pkg::BITS_PER_COLOR;
  localparam int unsigned LW = rlps_pkg::LEN_W;
  localparam int unsigned IW = rlps_pkg::CFG_IDX_W;
  localparam int unsigned DW = rlps_pkg::CFG_DATA_W;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic          in_opcode;
  logic [CB-1:0] in_red;
  logic [CB-1:0] in_green;
  logic [CB-1:0] in_blue;
  logic          in_last_pixel;
  logic          out_valid;
  logic          out_stall;
  logic          out_line_level;
  logic          out_busy_res;
  logic          out_pixel_accepted;
  logic          cfg_we;
  logic [IW-1:0] cfg_index;
  logic [DW-1:0] cfg_wdata;

  int fail_count;
  int pending_results;
  int results_checked;
  int pixels_taken;

  int idle_pct;
  int stall_pct;
  int beats_sent;
  int settings_run;

  always #1 clk = ~clk;

  rgb_led_pulse_serializer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .in_last_pixel      (in_last_pixel),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_line_level     (out_line_level),
    .out_busy_res       (out_busy_res),
    .out_pixel_accepted (out_pixel_accepted),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  rlps_pulse_check pulse_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .in_last_pixel      (in_last_pixel),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_line_level     (out_line_level),
    .out_busy_res       (out_busy_res),
    .out_pixel_accepted (out_pixel_accepted),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .pending_results    (pending_results),
    .results_checked    (results_checked),
    .pixels_taken       (pixels_taken)
  );

  // random color value
  function automatic logic [CB-1:0] rnd_color();
    int unsigned v;
    v = $urandom_range((1 << CB) - 1);
    return v[CB-1:0];
  endfunction

  // random register value from 0 to hi
  function automatic logic [LW-1:0] rnd_len(input int unsigned hi);
    int unsigned v;
    v = $urandom_range(hi);
    return v[LW-1:0];
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // one input beat: optional idle cycles, then hold until taken
  task automatic send_beat(input logic op, input logic [CB-1:0] r,
                           input logic [CB-1:0] g,
                           input logic [CB-1:0] b, input logic lst);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_red        <= r;
    in_green      <= g;
    in_blue       <= b;
    in_last_pixel <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic push_pixel(input logic [CB-1:0] r,
                            input logic [CB-1:0] g,
                            input logic [CB-1:0] b, input logic lst);
    send_beat(rlps_pkg::OP_PUSH, r, g, b, lst);
  endtask

  // ticks carry random payload, which the block must ignore
  task automatic tick_run(input int n);
    repeat (n) send_beat(rlps_pkg::OP_TICK, rnd_color(), rnd_color(),
                         rnd_color(), ($urandom_range(1) == 1));
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write all timing registers plus one write to an unmapped index
  task automatic load_timing(input logic [LW-1:0] zh, input logic [LW-1:0] zl,
                             input logic [LW-1:0] oh, input logic [LW-1:0] ol,
                             input logic [LW-1:0] lt);
    logic [IW-1:0] junk;
    int unsigned   v;
    v = $urandom_range((1 << IW) - 1, 32'(rlps_pkg::REG_LATCH) + 1);
    junk = v[IW-1:0];
    cfg_we    <= 1'b1;
    cfg_index <= rlps_pkg::REG_ZERO_HIGH;
    cfg_wdata <= zh;
    @(negedge clk);
    cfg_index <= rlps_pkg::REG_ZERO_LOW;
    cfg_wdata <= zl;
    @(negedge clk);
    cfg_index <= rlps_pkg::REG_ONE_HIGH;
    cfg_wdata <= oh;
    @(negedge clk);
    cfg_index <= rlps_pkg::REG_ONE_LOW;
    cfg_wdata <= ol;
    @(negedge clk);
    cfg_index <= rlps_pkg::REG_LATCH;
    cfg_wdata <= lt;
    @(negedge clk);
    cfg_index <= junk;
    cfg_wdata <= rnd_len(32'hffff);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    settings_run++;
  endtask

  // random mix of ticks and pushes
  task automatic run_mix(input int n, input int push_pct);
    repeat (n) begin
      if ($urandom_range(99) < push_pct)
        push_pixel(rnd_color(), rnd_color(), rnd_color(), ($urandom_range(2) == 0));
      else
        tick_run(1);
    end
  endtask

  initial begin
    int idle_table[4];
    int stall_table[4];
    idle_table  = '{0, 81, 0, 35};
    stall_table = '{0, 0, 81, 35};
    idle_pct      = 0;
    stall_pct     = 0;
    beats_sent    = 0;
    settings_run  = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = rlps_pkg::OP_TICK;
    in_red        = '0;
    in_green      = '0;
    in_blue       = '0;
    in_last_pixel = 1'b0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = rlps_pkg::REG_ZERO_HIGH;
    cfg_wdata     = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset timing: idle tick, fill, refuse while full, chain two pixels,
    // then run through the first high pulse into the low pulse
    tick_run(1);
    push_pixel(8'hff, 8'h00, 8'h5a, 1'b0);
    push_pixel(8'h00, 8'hff, 8'ha5, 1'b1);
    tick_run(1);
    push_pixel(8'h00, 8'hff, 8'ha5, 1'b1);
    push_pixel(8'h3c, 8'hc3, 8'h81, 1'b0);
    tick_run(45);
    wait_drained();

    // zero lengths act as one tick; finish the frame in flight, then a
    // pixel waiting at end of latch, then buffer running dry mid-frame
    load_timing('0, '0, '0, '0, '0);
    tick_run(120);
    push_pixel(8'h00, 8'hff, 8'h0f, 1'b1);
    tick_run(1);
    push_pixel(8'hff, 8'h00, 8'hf0, 1'b0);
    tick_run(100);
    push_pixel(8'h55, 8'haa, 8'h33, 1'b1);
    tick_run(52);
    wait_drained();

    // random phases under each idle/stall mix
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_table[p];
      stall_pct = stall_table[p];
      wait_drained();
      if (p == 0)
        load_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
      else
        load_timing(rnd_len(3), rnd_len(3), rnd_len(3), rnd_len(3), rnd_len(40));
      run_mix(25, 12);
      // hold off until the pipe is empty, then resume mid-frame
      wait_drained();
      run_mix(25, 12);
    end

    // longest pulse and latch lengths: the line holds high without wrapping
    wait_drained();
    load_timing(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    push_pixel(8'h00, 8'h80, 8'h00, 1'b1);
    tick_run(20);

    wait_drained();
    repeat (8) @(negedge clk);
    $display("sent %0d beats over %0d timing settings, idle/stall from 0 to 81 percent",
             beats_sent, settings_run);
    $display("checked %0d results, %0d pixels taken into the buffer",
             results_checked, pixels_taken);
    if (fail_count == 0 && pending_results == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("status: fail");
    $finish;
  end

endmodule
